// ===== rtl/core/mset_pkg.sv =====
// ----------------------------------------------------------------------------
// mset_pkg
// Shared types and constants for the multi-slot event timer unit.
// ----------------------------------------------------------------------------
package mset_pkg;

    localparam int NUM_SLOTS = 8;
    localparam int SLOT_AW   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W     = 32;
    localparam int TAG_W     = 8;
    localparam int IDX_W     = 6;

    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_REG   = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_REG   = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic [CNT_W-1:0] rld;
        logic [TAG_W-1:0] tag;
    } t_slot_word;

    typedef struct packed {
        logic [1:0]       kind;
        logic             fired;
        logic             success;
        logic [IDX_W-1:0] slot;
        logic [TAG_W-1:0] tag;
        logic             last;
    } t_result;

endpackage

// ===== rtl/core/mset_ram.sv =====
// ----------------------------------------------------------------------------
// mset_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module mset_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 8,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/mset_obuf.sv =====
// ----------------------------------------------------------------------------
// mset_obuf
// Two-entry result queue that decouples the slot engine from the output port.
// ----------------------------------------------------------------------------
module mset_obuf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  mset_pkg::t_result i_word,
    output logic              o_full,
    output logic              o_valid,
    input  logic              i_stall,
    output mset_pkg::t_result o_word
);

    mset_pkg::t_result r_mem [2];
    logic              r_wp;
    logic              r_rp;
    logic [1:0]        r_cnt;
    logic              w_push;
    logic              w_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_word  = r_mem[r_rp];
    assign w_push  = i_push && !o_full;
    assign w_pop   = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= !r_wp;
            end
            if (w_pop) begin
                r_rp <= !r_rp;
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== rtl/core/multi_slot_event_timer_unit.sv =====
// Register and clear words push their reply into the result queue as they are accepted.
// A tick walks every slot: a free slot takes a read state only, each used slot a read
// and an update state, and a full result queue can hold a firing update and the end state.
// Words are taken one at a time; a new word waits while a tick runs or the queue is full.
// Reset is synchronous and active low; it frees every slot and empties the result queue.
// The slot memory itself is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// multi_slot_event_timer_unit
// Timer slot table with a read-modify-write slot memory and a result queue.
// ----------------------------------------------------------------------------
module multi_slot_event_timer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_req_type,
    input  logic [31:0] i_ticks_from_now,
    input  logic [31:0] i_reload_value,
    input  logic [7:0]  i_event_tag,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_reply_kind,
    output logic        o_fired,
    output logic        o_success,
    output logic [5:0]  o_slot_index,
    output logic [7:0]  o_fired_tag,
    output logic        o_last
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD   = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;
    localparam logic [1:0] S_END  = 2'd3;

    localparam logic [mset_pkg::SLOT_AW-1:0] LAST_IDX =
        mset_pkg::SLOT_AW'(mset_pkg::NUM_SLOTS - 1);

    logic [1:0]                      r_state, n_state;
    logic [mset_pkg::SLOT_AW-1:0]    r_idx, n_idx;
    logic [mset_pkg::NUM_SLOTS-1:0]  r_used, n_used;
    mset_pkg::t_result               r_pend, n_pend;
    logic                            r_pend_v, n_pend_v;

    logic                            w_accept;
    logic                            w_free_found;
    logic [mset_pkg::SLOT_AW-1:0]    w_free_idx;
    logic                            w_we;
    logic [mset_pkg::SLOT_AW-1:0]    w_waddr;
    mset_pkg::t_slot_word            w_wdata;
    logic                            w_re;
    mset_pkg::t_slot_word            w_rdata;
    logic                            w_push;
    mset_pkg::t_result               w_push_word;
    logic                            w_full;
    mset_pkg::t_result               w_out_word;

    assign o_in_stall = (r_state != S_IDLE) || w_full;
    assign w_accept   = i_in_valid && !o_in_stall;

    always_comb begin
        w_free_found = 1'b0;
        w_free_idx   = '0;
        for (int i = mset_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                w_free_found = 1'b1;
                w_free_idx   = mset_pkg::SLOT_AW'(i);
            end
        end
    end

    mset_ram #(
        .WIDTH ($bits(mset_pkg::t_slot_word)),
        .DEPTH (mset_pkg::NUM_SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (r_idx),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_used      = r_used;
        n_pend      = r_pend;
        n_pend_v    = r_pend_v;
        w_we        = 1'b0;
        w_waddr     = r_idx;
        w_wdata     = w_rdata;
        w_re        = 1'b0;
        w_push      = 1'b0;
        w_push_word = '0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (i_req_type)
                        mset_pkg::REQ_TICK: begin
                            n_idx    = '0;
                            n_pend_v = 1'b0;
                            n_state  = S_RD;
                        end
                        mset_pkg::REQ_REG: begin
                            w_push           = 1'b1;
                            w_push_word.kind = mset_pkg::KIND_REG;
                            w_push_word.last = 1'b1;
                            if (w_free_found) begin
                                w_we                 = 1'b1;
                                w_waddr              = w_free_idx;
                                w_wdata.cnt          = i_ticks_from_now;
                                w_wdata.rld          = i_reload_value;
                                w_wdata.tag          = i_event_tag;
                                n_used[w_free_idx]   = 1'b1;
                                w_push_word.success  = 1'b1;
                                w_push_word.slot     = mset_pkg::IDX_W'(w_free_idx);
                            end
                        end
                        mset_pkg::REQ_CLEAR: begin
                            n_used           = '0;
                            w_push           = 1'b1;
                            w_push_word.kind = mset_pkg::KIND_CLEAR;
                            w_push_word.last = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_RD: begin
                if (r_used[r_idx]) begin
                    w_re    = 1'b1;
                    n_state = S_UPD;
                end else if (r_idx == LAST_IDX) begin
                    n_state = S_END;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_UPD: begin
                if (!((w_rdata.cnt == '0) && r_pend_v && w_full)) begin
                    if (w_rdata.cnt == '0) begin
                        w_push      = r_pend_v;
                        w_push_word = r_pend;
                        n_pend_v    = 1'b1;
                        n_pend      = '0;
                        n_pend.kind  = mset_pkg::KIND_TICK;
                        n_pend.fired = 1'b1;
                        n_pend.slot  = mset_pkg::IDX_W'(r_idx);
                        n_pend.tag   = w_rdata.tag;
                        if (w_rdata.rld != '0) begin
                            w_we        = 1'b1;
                            w_wdata.cnt = w_rdata.rld - 1'b1;
                        end else begin
                            n_used[r_idx] = 1'b0;
                        end
                    end else begin
                        w_we        = 1'b1;
                        w_wdata.cnt = w_rdata.cnt - 1'b1;
                    end
                    if (r_idx == LAST_IDX) begin
                        n_state = S_END;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_RD;
                    end
                end
            end
            S_END: begin
                if (!w_full) begin
                    w_push = 1'b1;
                    if (r_pend_v) begin
                        w_push_word = r_pend;
                    end else begin
                        w_push_word.kind = mset_pkg::KIND_TICK;
                    end
                    w_push_word.last = 1'b1;
                    n_pend_v         = 1'b0;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_idx    <= '0;
            r_used   <= '0;
            r_pend_v <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_used   <= n_used;
            r_pend_v <= n_pend_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
    end

    mset_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_word  (w_push_word),
        .o_full  (w_full),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_word  (w_out_word)
    );

    assign o_reply_kind = w_out_word.kind;
    assign o_fired      = w_out_word.fired;
    assign o_success    = w_out_word.success;
    assign o_slot_index = w_out_word.slot;
    assign o_fired_tag  = w_out_word.tag;
    assign o_last       = w_out_word.last;

    a_busy_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_in_stall)
        else $error("input taken while a tick is in progress");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("result pushed into a full queue");

    a_update_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD) |-> r_used[r_idx])
        else $error("update of a free slot");

    a_pend_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pend_v)
        else $error("pending fire result left behind after a tick");

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the multi-slot event timer unit. Requests are fed
// through a valid/stall channel, and a local copy of the slot table works out
// the replies and fired events that each accepted word must produce. Every
// result word is compared field by field, in order. The run covers several
// idle and stall mixes and one long output hold that backs up the input.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] REQ_UNKNOWN = 2'd3;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 2 * mset_pkg::NUM_SLOTS + 10;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        logic [1:0]  req;
        logic [31:0] ticks;
        logic [31:0] period;
        logic [7:0]  tag;
    } t_request;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_req_type = '0;
    logic [31:0] i_ticks_from_now = '0;
    logic [31:0] i_reload_value = '0;
    logic [7:0]  i_event_tag = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [1:0]  o_reply_kind;
    logic        o_fired;
    logic        o_success;
    logic [5:0]  o_slot_index;
    logic [7:0]  o_fired_tag;
    logic        o_last;

    t_request          request_queue[$];
    mset_pkg::t_result due_replies[$];

    logic        slot_busy   [mset_pkg::NUM_SLOTS] = '{default: 1'b0};
    logic [31:0] slot_left   [mset_pkg::NUM_SLOTS] = '{default: '0};
    logic [31:0] slot_period [mset_pkg::NUM_SLOTS] = '{default: '0};
    logic [7:0]  slot_label  [mset_pkg::NUM_SLOTS] = '{default: '0};

    int in_idle_pct = 0;
    int out_stall_pct = 0;
    int hold_target = 0;
    int held_cycles = 0;
    int error_count = 0;
    int quiet_cycles = 0;

    multi_slot_event_timer_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_req_type       (i_req_type),
        .i_ticks_from_now (i_ticks_from_now),
        .i_reload_value   (i_reload_value),
        .i_event_tag      (i_event_tag),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_reply_kind     (o_reply_kind),
        .o_fired          (o_fired),
        .o_success        (o_success),
        .o_slot_index     (o_slot_index),
        .o_fired_tag      (o_fired_tag),
        .o_last           (o_last)
    );

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic step_slot_table(input t_request rq);
        mset_pkg::t_result hits[$];
        mset_pkg::t_result r;
        int free_slot;
        free_slot = -1;
        case (rq.req)
            mset_pkg::REQ_TICK: begin
                for (int i = 0; i < mset_pkg::NUM_SLOTS; i++) begin
                    if (slot_busy[i]) begin
                        if (slot_left[i] == 0) begin
                            r = '0;
                            r.kind = mset_pkg::KIND_TICK;
                            r.fired = 1'b1;
                            r.slot = mset_pkg::IDX_W'(i);
                            r.tag = slot_label[i];
                            hits.push_back(r);
                            if (slot_period[i] != 0) begin
                                slot_left[i] = slot_period[i];
                            end else begin
                                slot_busy[i] = 1'b0;
                            end
                        end
                        if (slot_busy[i]) begin
                            slot_left[i] = slot_left[i] - 32'd1;
                        end
                    end
                end
                if (hits.size() == 0) begin
                    r = '0;
                    r.kind = mset_pkg::KIND_TICK;
                    r.last = 1'b1;
                    hits.push_back(r);
                end else begin
                    hits[hits.size() - 1].last = 1'b1;
                end
            end
            mset_pkg::REQ_REG: begin
                for (int i = mset_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
                    if (!slot_busy[i]) begin
                        free_slot = i;
                    end
                end
                r = '0;
                r.kind = mset_pkg::KIND_REG;
                r.last = 1'b1;
                if (free_slot >= 0) begin
                    slot_busy[free_slot] = 1'b1;
                    slot_left[free_slot] = rq.ticks;
                    slot_period[free_slot] = rq.period;
                    slot_label[free_slot] = rq.tag;
                    r.success = 1'b1;
                    r.slot = mset_pkg::IDX_W'(free_slot);
                end
                hits.push_back(r);
            end
            mset_pkg::REQ_CLEAR: begin
                foreach (slot_busy[i]) begin
                    slot_busy[i] = 1'b0;
                end
                r = '0;
                r.kind = mset_pkg::KIND_CLEAR;
                r.last = 1'b1;
                hits.push_back(r);
            end
            default: begin
            end
        endcase
        foreach (hits[k]) begin
            due_replies.push_back(hits[k]);
        end
    endtask

    task automatic push_request(input logic [1:0] req, input logic [31:0] ticks,
                                input logic [31:0] period, input logic [7:0] tag);
        t_request rq;
        rq.req = req;
        rq.ticks = ticks;
        rq.period = period;
        rq.tag = tag;
        request_queue.push_back(rq);
    endtask

    task automatic queue_random_requests(input int count);
        int pick;
        int sel;
        logic [31:0] ticks;
        logic [31:0] period;
        repeat (count) begin
            pick = $urandom_range(99);
            if (pick < 52) begin
                push_request(mset_pkg::REQ_TICK, $urandom(), $urandom(), 8'($urandom()));
            end else if (pick < 88) begin
                sel = $urandom_range(9);
                ticks = (sel == 0) ? $urandom() : 32'($urandom_range(10));
                sel = $urandom_range(9);
                if (sel < 4) begin
                    period = '0;
                end else if (sel < 9) begin
                    period = 32'($urandom_range(8, 1));
                end else begin
                    period = $urandom();
                end
                push_request(mset_pkg::REQ_REG, ticks, period, 8'($urandom()));
            end else if (pick < 95) begin
                push_request(mset_pkg::REQ_CLEAR, $urandom(), $urandom(), 8'($urandom()));
            end else begin
                push_request(REQ_UNKNOWN, $urandom(), $urandom(), 8'($urandom()));
            end
        end
    endtask

    task automatic wait_until_drained();
        while (request_queue.size() != 0 || due_replies.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic run_phase(input int count, input int idle_pct, input int stall_pct,
                             input int hold);
        in_idle_pct = idle_pct;
        out_stall_pct = stall_pct;
        if (hold > 0) begin
            hold_target = held_cycles + hold;
        end
        queue_random_requests(count);
        wait_until_drained();
    endtask

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin : drive_requests
        t_request rq;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                rq.req = i_req_type;
                rq.ticks = i_ticks_from_now;
                rq.period = i_reload_value;
                rq.tag = i_event_tag;
                step_slot_table(rq);
                void'(request_queue.pop_front());
            end
            if (!(i_in_valid && o_in_stall)) begin
                if (request_queue.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
                    rq = request_queue[0];
                    i_in_valid <= 1'b1;
                    i_req_type <= rq.req;
                    i_ticks_from_now <= rq.ticks;
                    i_reload_value <= rq.period;
                    i_event_tag <= rq.tag;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : drive_stall
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (held_cycles < hold_target) begin
            i_out_stall <= 1'b1;
            held_cycles <= held_cycles + 1;
        end else begin
            i_out_stall <= ($urandom_range(99) < out_stall_pct);
        end
    end

    always @(posedge i_clk) begin : check_results
        mset_pkg::t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (due_replies.size() == 0) begin
                report_mismatch($sformatf("unexpected word kind %0d slot %0d tag %0h",
                                          o_reply_kind, o_slot_index, o_fired_tag));
            end else begin
                want = due_replies.pop_front();
                if (o_reply_kind !== want.kind) begin
                    report_mismatch($sformatf("reply_kind %0d, expected %0d",
                                              o_reply_kind, want.kind));
                end
                if (o_fired !== want.fired) begin
                    report_mismatch($sformatf("fired %0b, expected %0b", o_fired, want.fired));
                end
                if (o_success !== want.success) begin
                    report_mismatch($sformatf("success %0b, expected %0b",
                                              o_success, want.success));
                end
                if (o_slot_index !== want.slot) begin
                    report_mismatch($sformatf("slot_index %0d, expected %0d",
                                              o_slot_index, want.slot));
                end
                if (o_fired_tag !== want.tag) begin
                    report_mismatch($sformatf("fired_tag %0h, expected %0h",
                                              o_fired_tag, want.tag));
                end
                if (o_last !== want.last) begin
                    report_mismatch($sformatf("last %0b, expected %0b", o_last, want.last));
                end
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Fill the table, watch one-shot and recurring slots fire, overflow it,
        // then clear and fire every slot on one tick.
        push_request(mset_pkg::REQ_REG, 32'h0, 32'h0, 8'hFF);
        push_request(mset_pkg::REQ_REG, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h00);
        push_request(mset_pkg::REQ_REG, 32'd1, 32'd2, 8'hA5);
        push_request(mset_pkg::REQ_REG, 32'd0, 32'd1, 8'h5A);
        repeat (3) push_request(mset_pkg::REQ_TICK, 32'h0, 32'h0, 8'h00);
        push_request(mset_pkg::REQ_REG, 32'd3, 32'd0, 8'h01);
        push_request(mset_pkg::REQ_REG, 32'd0, 32'd0, 8'h10);
        push_request(mset_pkg::REQ_REG, 32'd0, 32'd0, 8'h20);
        push_request(mset_pkg::REQ_REG, 32'd0, 32'd0, 8'h40);
        push_request(mset_pkg::REQ_REG, 32'd0, 32'd0, 8'h80);
        push_request(mset_pkg::REQ_REG, 32'hFFFF_FFFF, 32'h0, 8'h77);
        push_request(REQ_UNKNOWN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
        push_request(mset_pkg::REQ_CLEAR, 32'h0, 32'h0, 8'h00);
        push_request(mset_pkg::REQ_TICK, 32'h0, 32'h0, 8'h00);
        for (int k = 0; k < mset_pkg::NUM_SLOTS; k++) begin
            push_request(mset_pkg::REQ_REG, 32'd0, 32'(k % 2), 8'(k * 37 + 1));
        end
        push_request(mset_pkg::REQ_TICK, 32'h0, 32'h0, 8'h00);
        wait_until_drained();

        run_phase(90, 0, 0, 0);
        run_phase(80, 75, 0, 0);
        run_phase(80, 0, 75, 0);
        run_phase(80, 21, 21, 0);
        run_phase(40, 0, 0, HOLD_CYCLES);
        run_phase(40, 21, 21, 0);

        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (due_replies.size() != 0) begin
            report_mismatch($sformatf("%0d expected words never arrived", due_replies.size()));
        end
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/mset_pkg.sv
rtl/core/mset_ram.sv
rtl/core/mset_obuf.sv
rtl/core/multi_slot_event_timer_unit.sv
tb/tb_top.sv
